// ----- src/pufr_pkg.sv -----
// Package for the parity union-find with rollback block.
// Holds opcodes, status codes, and the command and status bundles shared by
// the controller and the datapath. Depends on nothing.
`default_nettype none

package pufr_pkg;

    localparam logic [2:0] OP_UNITE  = 3'd0;
    localparam logic [2:0] OP_UNDO1  = 3'd1;
    localparam logic [2:0] OP_UNDOTO = 3'd2;
    localparam logic [2:0] OP_FLIP   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // The 10-bit vertex fields are reduced with one conditional subtract per bit.
    localparam logic [3:0] RED_LAST_STEP = 4'd9;

    typedef enum logic [1:0] {
        RD_CUR    = 2'd0,
        RD_REC_LO = 2'd1,
        RD_REC_UP = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_CLR    = 3'd1,
        WR_LOWER  = 3'd2,
        WR_UPPER  = 3'd3,
        WR_FLIP   = 3'd4,
        WR_POP_UP = 3'd5,
        WR_POP_LO = 3'd6
    } wr_sel_t;

    typedef struct packed {
        logic    ld_in;
        logic    red_step;
        logic    start_a;
        logic    start_b;
        logic    find_step;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    cap_b;
        wr_sel_t wr_sel;
        logic    hist_push;
        logic    push_link;
        logic    hist_rd;
        logic    pop_apply;
        logic    tgt_one;
        logic    tgt_in;
        logic    st_full;
        logic    st_bad;
        logic    clr_start;
        logic    clr_step;
        logic    clr_all;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic       red_last;
        logic       is_root;
        logic       same_root;
        logic       hist_full;
        logic       hist_empty;
        logic       tgt_bad;
        logic       at_target;
        logic       rec_linked;
        logic       clr_last;
        logic       out_free;
        logic       flag;
        logic [2:0] opcode;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/pufr_dpath.sv -----
// Datapath of the parity union-find: vertex row memory, history memory,
// root-walk registers, counters and the output register. Uses pufr_pkg.
`default_nettype none

module pufr_dpath #(
    parameter int NUM_VERTICES  = 1024,
    parameter int HISTORY_DEPTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pufr_pkg::cmd_t   cmd,
    output pufr_pkg::stat_t       stat,
    input  wire logic [2:0]       opcode,
    input  wire logic [9:0]       vertex_a,
    input  wire logic [9:0]       vertex_b,
    input  wire logic [10:0]      target_version,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [9:0]            root_out,
    output logic                  color_out,
    output logic                  is_bipartite,
    output logic [10:0]           version_out,
    output logic [1:0]            status
);

    localparam int VW  = $clog2(NUM_VERTICES);
    localparam int SW  = VW + 1;
    localparam int RW  = VW + 1 + SW;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HW  = 2 * VW + 3;
    localparam logic [26:0] NV_W      = 27'(NUM_VERTICES);
    localparam logic [VW-1:0] V_LAST  = VW'(NUM_VERTICES - 1);
    localparam logic [HCW-1:0] HC_MAX = HCW'(HISTORY_DEPTH);

    logic [2:0]     op_reg;
    logic [9:0]     a_red_reg, b_red_reg;
    logic [10:0]    tin_reg;
    logic [3:0]     k_reg;
    logic [HCW-1:0] tgt_reg;
    logic [1:0]     st_reg;
    logic [VW-1:0]  cur_reg;
    logic           col_reg;
    logic [RW-1:0]  vr_reg;
    logic [VW-1:0]  ra_reg, rb_reg;
    logic           ca_reg, cb_reg;
    logic [RW-1:0]  rowa_reg, rowb_reg;
    logic           flag_reg;
    logic [HCW-1:0] hc_reg;
    logic [HW-1:0]  hr_reg;

    logic [RW-1:0]  vmem [NUM_VERTICES];
    logic [HW-1:0]  hmem [HISTORY_DEPTH];

    // Vertex reduction modulo the store size.
    logic [26:0] sh;
    logic [31:0] a32, b32, hc32, hm32, tin32, ra32;
    logic [VW-1:0] a_v, b_v;
    assign sh    = NV_W << k_reg;
    assign a32   = 32'(a_red_reg);
    assign b32   = 32'(b_red_reg);
    assign a_v   = a32[VW-1:0];
    assign b_v   = b32[VW-1:0];
    assign hc32  = 32'(hc_reg);
    assign hm32  = 32'(hc_reg - HCW'(1));
    assign tin32 = 32'(tin_reg);
    assign ra32  = 32'(ra_reg);

    // Fields of the row read back and of the captured roots.
    logic [VW-1:0] vr_parent;
    logic          vr_par;
    assign vr_parent = vr_reg[RW-1:SW+1];
    assign vr_par    = vr_reg[SW];

    logic [SW-1:0] sza, szb;
    logic          pa, pb;
    logic [VW-1:0] pra, prb;
    assign sza = rowa_reg[SW-1:0];
    assign szb = rowb_reg[SW-1:0];
    assign pa  = rowa_reg[SW];
    assign pb  = rowb_reg[SW];
    assign pra = rowa_reg[RW-1:SW+1];
    assign prb = rowb_reg[RW-1:SW+1];

    // Link decision: the smaller tree goes under the other, ties put b under a.
    logic          swap, flip;
    logic [VW-1:0] upper, lower;
    logic          p_lo, p_up;
    logic [SW-1:0] s_lo, s_up;
    assign swap  = sza < szb;
    assign flip  = ca_reg == cb_reg;
    assign upper = swap ? rb_reg : ra_reg;
    assign lower = swap ? ra_reg : rb_reg;
    assign p_lo  = swap ? pa : pb;
    assign p_up  = swap ? pb : pa;
    assign s_lo  = swap ? sza : szb;
    assign s_up  = swap ? szb : sza;

    // History record: {upper, lower, flipped, old_flag, linked}.
    logic [VW-1:0] h_up, h_lo;
    logic          h_flip, h_old, h_link;
    assign h_up   = hr_reg[HW-1 -: VW];
    assign h_lo   = hr_reg[HW-VW-1 -: VW];
    assign h_flip = hr_reg[2];
    assign h_old  = hr_reg[1];
    assign h_link = hr_reg[0];

    logic [HW-1:0] push_rec;
    assign push_rec = cmd.push_link ? {upper, lower, flip, flag_reg, 1'b1}
                                    : {{(2 * VW + 1){1'b0}}, flag_reg, 1'b0};

    // Vertex memory ports.
    logic [VW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data;
    logic          wr_en;

    always_comb
    begin
        case (cmd.rd_sel)
            pufr_pkg::RD_REC_LO: rd_addr = h_lo;
            pufr_pkg::RD_REC_UP: rd_addr = h_up;
            default:             rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = cur_reg;
        wr_data = {cur_reg, 1'b0, SW'(1)};
        case (cmd.wr_sel)
            pufr_pkg::WR_CLR:
            begin
                wr_addr = cur_reg;
                wr_data = {cur_reg, 1'b0, SW'(1)};
            end
            pufr_pkg::WR_LOWER:
            begin
                wr_addr = lower;
                wr_data = {upper, p_lo ^ flip, s_lo};
            end
            pufr_pkg::WR_UPPER:
            begin
                wr_addr = upper;
                wr_data = {upper, p_up, s_up + s_lo};
            end
            pufr_pkg::WR_FLIP:
            begin
                wr_addr = ra_reg;
                wr_data = {pra, ~pa, sza};
            end
            pufr_pkg::WR_POP_UP:
            begin
                wr_addr = h_up;
                wr_data = {prb, pb, szb - sza};
            end
            pufr_pkg::WR_POP_LO:
            begin
                wr_addr = h_lo;
                wr_data = {h_lo, pa ^ h_flip, sza};
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vmem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            vr_reg <= vmem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_push)
        begin
            hmem[hc32[HAW-1:0]] <= push_rec;
        end
        if (cmd.hist_rd)
        begin
            hr_reg <= hmem[hm32[HAW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            op_reg    <= opcode;
            a_red_reg <= vertex_a;
            b_red_reg <= vertex_b;
            tin_reg   <= target_version;
            st_reg    <= pufr_pkg::ST_OK;
        end
        if (cmd.red_step)
        begin
            if ({17'b0, a_red_reg} >= sh)
            begin
                a_red_reg <= a_red_reg - sh[9:0];
            end
            if ({17'b0, b_red_reg} >= sh)
            begin
                b_red_reg <= b_red_reg - sh[9:0];
            end
        end
        if (cmd.st_full)
        begin
            st_reg <= pufr_pkg::ST_FULL;
        end
        if (cmd.st_bad)
        begin
            st_reg <= pufr_pkg::ST_BAD;
        end
        if (cmd.tgt_one)
        begin
            tgt_reg <= hc_reg - HCW'(1);
        end
        if (cmd.tgt_in)
        begin
            tgt_reg <= tin32[HCW-1:0];
        end
        if (cmd.start_a || cmd.start_b)
        begin
            col_reg <= 1'b0;
        end
        if (cmd.find_step)
        begin
            col_reg <= col_reg ^ vr_par;
        end
        if (cmd.cap_a)
        begin
            ra_reg   <= cur_reg;
            ca_reg   <= col_reg ^ vr_par;
            rowa_reg <= vr_reg;
        end
        if (cmd.cap_b)
        begin
            rb_reg   <= cur_reg;
            cb_reg   <= col_reg ^ vr_par;
            rowb_reg <= vr_reg;
        end
        if (cmd.out_load)
        begin
            root_out     <= ra32[9:0];
            color_out    <= ca_reg;
            is_bipartite <= flag_reg;
            version_out  <= hc32[10:0];
            status       <= st_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= pufr_pkg::RED_LAST_STEP;
            cur_reg   <= '0;
            flag_reg  <= 1'b1;
            hc_reg    <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.ld_in)
            begin
                k_reg <= pufr_pkg::RED_LAST_STEP;
            end
            else if (cmd.red_step)
            begin
                k_reg <= k_reg - 4'd1;
            end
            if (cmd.start_a)
            begin
                cur_reg <= a_v;
            end
            else if (cmd.start_b)
            begin
                cur_reg <= b_v;
            end
            else if (cmd.find_step)
            begin
                cur_reg <= vr_parent;
            end
            else if (cmd.clr_start)
            begin
                cur_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                cur_reg <= cur_reg + VW'(1);
            end
            if (cmd.hist_push)
            begin
                hc_reg <= hc_reg + HCW'(1);
                if (!cmd.push_link)
                begin
                    flag_reg <= flag_reg & ~((ra_reg == rb_reg) & flip);
                end
            end
            else if (cmd.pop_apply)
            begin
                hc_reg   <= hc_reg - HCW'(1);
                flag_reg <= h_old;
            end
            else if (cmd.clr_all)
            begin
                hc_reg   <= '0;
                flag_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign stat.red_last   = k_reg == 4'd0;
    assign stat.is_root    = vr_parent == cur_reg;
    assign stat.same_root  = ra_reg == rb_reg;
    assign stat.hist_full  = hc_reg >= HC_MAX;
    assign stat.hist_empty = hc_reg == '0;
    assign stat.tgt_bad    = tin32 > hc32;
    assign stat.at_target  = hc_reg == tgt_reg;
    assign stat.rec_linked = h_link;
    assign stat.clr_last   = cur_reg == V_LAST;
    assign stat.out_free   = ~out_valid | out_ready;
    assign stat.flag       = flag_reg;
    assign stat.opcode     = op_reg;

    a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hc32 <= HISTORY_DEPTH)
        else $error("history count beyond depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_push |=> hc_reg == $past(hc_reg) + HCW'(1))
        else $error("push did not advance the history count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_apply |-> hc_reg != '0)
        else $error("pop on an empty history");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_a || cmd.start_b) |-> (a32 < NUM_VERTICES && b32 < NUM_VERTICES))
        else $error("vertex not reduced below the store size");

endmodule

`default_nettype wire

// ----- src/pufr_ctrl.sv -----
// Controller state machine of the parity union-find. Sequences reduction,
// root walks, linking, flips, rollback, clearing and result hand-off. Uses pufr_pkg.
`default_nettype none

module pufr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pufr_pkg::stat_t stat,
    output pufr_pkg::cmd_t       cmd
);

    typedef enum logic [23:0] {
        S_CLR_RST = 24'h000001,
        S_IDLE    = 24'h000002,
        S_RED     = 24'h000004,
        S_DEC     = 24'h000008,
        S_FA_RD   = 24'h000010,
        S_FA_CHK  = 24'h000020,
        S_FB_RD   = 24'h000040,
        S_FB_CHK  = 24'h000080,
        S_JOIN    = 24'h000100,
        S_NOOP    = 24'h000200,
        S_LINK_LO = 24'h000400,
        S_LINK_UP = 24'h000800,
        S_FLIP    = 24'h001000,
        S_P_TEST  = 24'h002000,
        S_P_HRD   = 24'h004000,
        S_P_REC   = 24'h008000,
        S_P_LO    = 24'h010000,
        S_P_UP    = 24'h020000,
        S_P_WU    = 24'h040000,
        S_P_WL    = 24'h080000,
        S_CLR_OP  = 24'h100000,
        S_FO_RD   = 24'h200000,
        S_FO_CHK  = 24'h400000,
        S_OUT     = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = pufr_pkg::RD_CUR;
        cmd.wr_sel = pufr_pkg::WR_NONE;
        state_next = state_reg;
        case (state_reg)
            S_CLR_RST:
            begin
                cmd.wr_sel   = pufr_pkg::WR_CLR;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.red_step = 1'b1;
                if (stat.red_last)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.opcode)
                    pufr_pkg::OP_UNITE:
                    begin
                        if (stat.hist_full)
                        begin
                            cmd.st_full = 1'b1;
                            cmd.start_a = 1'b1;
                            state_next  = S_FO_RD;
                        end
                        else if (!stat.flag)
                        begin
                            state_next = S_NOOP;
                        end
                        else
                        begin
                            cmd.start_a = 1'b1;
                            state_next  = S_FA_RD;
                        end
                    end
                    pufr_pkg::OP_UNDO1:
                    begin
                        if (stat.hist_empty)
                        begin
                            cmd.st_bad  = 1'b1;
                            cmd.start_a = 1'b1;
                            state_next  = S_FO_RD;
                        end
                        else
                        begin
                            cmd.tgt_one = 1'b1;
                            state_next  = S_P_TEST;
                        end
                    end
                    pufr_pkg::OP_UNDOTO:
                    begin
                        if (stat.tgt_bad)
                        begin
                            cmd.st_bad  = 1'b1;
                            cmd.start_a = 1'b1;
                            state_next  = S_FO_RD;
                        end
                        else
                        begin
                            cmd.tgt_in = 1'b1;
                            state_next = S_P_TEST;
                        end
                    end
                    pufr_pkg::OP_FLIP:
                    begin
                        cmd.start_a = 1'b1;
                        state_next  = S_FA_RD;
                    end
                    pufr_pkg::OP_CLEAR:
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_CLR_OP;
                    end
                    default:
                    begin
                        cmd.start_a = 1'b1;
                        state_next  = S_FO_RD;
                    end
                endcase
            end
            S_FA_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_FA_CHK;
            end
            S_FA_CHK:
            begin
                if (stat.is_root)
                begin
                    cmd.cap_a = 1'b1;
                    if (stat.opcode == pufr_pkg::OP_FLIP)
                    begin
                        state_next = S_FLIP;
                    end
                    else
                    begin
                        cmd.start_b = 1'b1;
                        state_next  = S_FB_RD;
                    end
                end
                else
                begin
                    cmd.find_step = 1'b1;
                    state_next    = S_FA_RD;
                end
            end
            S_FB_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_FB_CHK;
            end
            S_FB_CHK:
            begin
                if (stat.is_root)
                begin
                    cmd.cap_b  = 1'b1;
                    state_next = S_JOIN;
                end
                else
                begin
                    cmd.find_step = 1'b1;
                    state_next    = S_FB_RD;
                end
            end
            S_JOIN:
            begin
                state_next = stat.same_root ? S_NOOP : S_LINK_LO;
            end
            S_NOOP:
            begin
                cmd.hist_push = 1'b1;
                cmd.start_a   = 1'b1;
                state_next    = S_FO_RD;
            end
            S_LINK_LO:
            begin
                cmd.wr_sel = pufr_pkg::WR_LOWER;
                state_next = S_LINK_UP;
            end
            S_LINK_UP:
            begin
                cmd.wr_sel    = pufr_pkg::WR_UPPER;
                cmd.hist_push = 1'b1;
                cmd.push_link = 1'b1;
                cmd.start_a   = 1'b1;
                state_next    = S_FO_RD;
            end
            S_FLIP:
            begin
                cmd.wr_sel  = pufr_pkg::WR_FLIP;
                cmd.start_a = 1'b1;
                state_next  = S_FO_RD;
            end
            S_P_TEST:
            begin
                if (stat.at_target)
                begin
                    cmd.start_a = 1'b1;
                    state_next  = S_FO_RD;
                end
                else
                begin
                    state_next = S_P_HRD;
                end
            end
            S_P_HRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_P_REC;
            end
            S_P_REC:
            begin
                if (stat.rec_linked)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = pufr_pkg::RD_REC_LO;
                    state_next = S_P_LO;
                end
                else
                begin
                    cmd.pop_apply = 1'b1;
                    state_next    = S_P_TEST;
                end
            end
            S_P_LO:
            begin
                cmd.cap_a  = 1'b1;
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = pufr_pkg::RD_REC_UP;
                state_next = S_P_UP;
            end
            S_P_UP:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_P_WU;
            end
            S_P_WU:
            begin
                cmd.wr_sel = pufr_pkg::WR_POP_UP;
                state_next = S_P_WL;
            end
            S_P_WL:
            begin
                cmd.wr_sel    = pufr_pkg::WR_POP_LO;
                cmd.pop_apply = 1'b1;
                state_next    = S_P_TEST;
            end
            S_CLR_OP:
            begin
                cmd.wr_sel   = pufr_pkg::WR_CLR;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.clr_all  = 1'b1;
                    cmd.clr_step = 1'b0;
                    cmd.start_a  = 1'b1;
                    state_next   = S_FO_RD;
                end
            end
            S_FO_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_FO_CHK;
            end
            S_FO_CHK:
            begin
                if (stat.is_root)
                begin
                    cmd.cap_a  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.find_step = 1'b1;
                    state_next    = S_FO_RD;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_one_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_RED)
        else $error("accepted beat did not start reduction");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken result");

    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR_RST || state_reg == S_CLR_OP) |-> !in_ready)
        else $error("input taken during a clearing pass");

endmodule

`default_nettype wire

// ----- src/parity_union_find_rollback.sv -----
// A query walks from vertex_a to its root; a flip adds a walk and then flips that root.
// A unite adds two root walks, one from each vertex, and then links the two roots; rollback
// pops no-op and linked records one at a time; clear rewrites every vertex row.
// One beat in flight; the next one is taken right after the result is loaded.
// Depth is at most log2(NUM_VERTICES).
// Reset is asynchronous and active low; a clearing pass over every vertex row precedes input.
`default_nettype none

module parity_union_find_rollback #(
    parameter int NUM_VERTICES  = 1024,
    parameter int HISTORY_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [9:0]  vertex_a,
    input  wire logic [9:0]  vertex_b,
    input  wire logic [10:0] target_version,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       root_out,
    output logic             color_out,
    output logic             is_bipartite,
    output logic [10:0]      version_out,
    output logic [1:0]       status
);

    // The controller only issues commands; all state of the disjoint-set store,
    // the history stack and the result register lives in the datapath. The
    // result register lets a finished beat wait for out_ready while the
    // controller returns to idle and takes the next input beat.
    pufr_pkg::cmd_t  cmd;
    pufr_pkg::stat_t stat;

    pufr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pufr_dpath #(
        .NUM_VERTICES  (NUM_VERTICES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .target_version (target_version),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .root_out       (root_out),
        .color_out      (color_out),
        .is_bipartite   (is_bipartite),
        .version_out    (version_out),
        .status         (status)
    );

endmodule

`default_nettype wire
